// File: src/nlfd_pkg.sv
package nlfd_pkg;

   // Character codes of interest.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_POINT = 8'h2E;

   // Saturation limit of the whole part (DDDMM) and fraction limits.
   localparam logic [14:0] WHOLE_MAX       = 15'd18099;
   localparam logic [2:0]  FRAC_MAX_DIGITS = 3'd6;
   localparam logic [2:0]  COUNT_MAX       = 3'd7;

   // Reciprocal constants.
   // whole / 100 = (whole * DIV100_MUL) >> DIV100_SHIFT for whole <= 18099.
   localparam logic [12:0] DIV100_MUL   = 13'd5243;
   localparam int          DIV100_SHIFT = 19;
   // x / 60 = (x * DIV60_MUL) >> DIV60_SHIFT for x < 10^7.
   localparam logic [24:0] DIV60_MUL    = 25'd17895698;
   localparam int          DIV60_SHIFT  = 30;
   // floor(mins * 10^7 / 60) = (mins * MINS_MUL) >> MINS_SHIFT for mins < 100.
   localparam logic [25:0] MINS_MUL     = 26'd42666667;
   localparam int          MINS_SHIFT   = 8;

   localparam logic [6:0]  HUNDRED      = 7'd100;
   localparam logic [23:0] DEG_SCALE    = 24'd10000000;

   // Snapshot of the accumulated field, handed over on the final character.
   typedef struct packed {
      logic        valid;
      logic [14:0] whole;
      logic [19:0] frac;
      logic [2:0]  count;
      logic        negate;
      logic        saturated;
   } snap_type;

   // Scale that brings a fraction of n digits to seven digits.
   function automatic logic [19:0] frac_scale(input logic [2:0] count);
      logic [19:0] scale;
      case (count)
         3'd1:    scale = 20'd1000000;
         3'd2:    scale = 20'd100000;
         3'd3:    scale = 20'd10000;
         3'd4:    scale = 20'd1000;
         3'd5:    scale = 20'd100;
         3'd6:    scale = 20'd10;
         default: scale = 20'd0;
      endcase
      return scale;
   endfunction

endpackage

// File: src/nlfd_accum.sv
module nlfd_accum (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_char_code,
   input  logic               req_field_end,
   input  logic               req_negate_hemisphere,
   input  logic               conv_ready,
   output nlfd_pkg::snap_type snap
);
   import nlfd_pkg::*;

   logic [14:0] whole_ff, whole_in;
   logic        whole_stop_ff, whole_stop_in;
   logic        whole_sat_ff, whole_sat_in;
   logic        point_ff, point_in;
   logic [19:0] frac_ff, frac_in;
   logic        frac_stop_ff, frac_stop_in;
   logic [2:0]  count_ff, count_in;
   snap_type    snap_ff, snap_in;

   logic        accept;
   logic        digit;
   logic [3:0]  digit_val;
   logic [17:0] whole_next;

   assign req_stall = snap_ff.valid && !conv_ready;
   assign accept    = req_valid && !req_stall;
   assign snap      = snap_ff;

   assign digit      = (req_char_code >= CHAR_ZERO) && (req_char_code <= CHAR_NINE);
   assign digit_val  = digit ? 4'(req_char_code - CHAR_ZERO) : 4'd0;
   assign whole_next = 18'(whole_ff) * 18'd10 + 18'(digit_val);

   always_comb begin
      whole_in      = whole_ff;
      whole_stop_in = whole_stop_ff;
      whole_sat_in  = whole_sat_ff;
      point_in      = point_ff;
      frac_in       = frac_ff;
      frac_stop_in  = frac_stop_ff;
      count_in      = count_ff;
      if (!point_ff) begin
         if (req_char_code == CHAR_POINT) begin
            point_in = 1'b1;
         end else if (!digit) begin
            whole_stop_in = 1'b1;
         end else if (!whole_stop_ff) begin
            if (whole_sat_ff || whole_next > 18'(WHOLE_MAX)) begin
               whole_in     = WHOLE_MAX;
               whole_sat_in = 1'b1;
            end else begin
               whole_in = whole_next[14:0];
            end
         end
      end else begin
         if (!digit) begin
            frac_stop_in = 1'b1;
         end else if (!frac_stop_ff && count_ff < FRAC_MAX_DIGITS) begin
            frac_in = 20'(frac_ff * 20'd10 + 20'(digit_val));
         end
         if (count_ff < COUNT_MAX) begin
            count_in = count_ff + 3'd1;
         end
      end
   end

   always_comb begin
      snap_in = snap_ff;
      if (conv_ready) begin
         snap_in.valid = 1'b0;
      end
      if (accept && req_field_end) begin
         snap_in.valid     = 1'b1;
         snap_in.whole     = whole_in;
         snap_in.frac      = frac_in;
         snap_in.count     = count_in;
         snap_in.negate    = req_negate_hemisphere;
         snap_in.saturated = whole_sat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_ff <= '0;
      end else begin
         snap_ff <= snap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         whole_ff      <= '0;
         whole_stop_ff <= 1'b0;
         whole_sat_ff  <= 1'b0;
         point_ff      <= 1'b0;
         frac_ff       <= '0;
         frac_stop_ff  <= 1'b0;
         count_ff      <= '0;
      end else if (accept) begin
         if (req_field_end) begin
            whole_ff      <= '0;
            whole_stop_ff <= 1'b0;
            whole_sat_ff  <= 1'b0;
            point_ff      <= 1'b0;
            frac_ff       <= '0;
            frac_stop_ff  <= 1'b0;
            count_ff      <= '0;
         end else begin
            whole_ff      <= whole_in;
            whole_stop_ff <= whole_stop_in;
            whole_sat_ff  <= whole_sat_in;
            point_ff      <= point_in;
            frac_ff       <= frac_in;
            frac_stop_ff  <= frac_stop_in;
            count_ff      <= count_in;
         end
      end
   end

endmodule

// File: src/nlfd_convert.sv
module nlfd_convert (
   input  logic               clock,
   input  logic               reset,
   input  nlfd_pkg::snap_type snap,
   output logic               conv_ready,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_degrees_e7,
   output logic               rsp_over_range
);
   import nlfd_pkg::*;

   // Stage two: degrees split off and fraction scaled to seven digits.
   logic        v2_ff;
   logic [14:0] whole2_ff;
   logic [7:0]  deg2_ff;
   logic [23:0] fprod2_ff;
   logic        neg2_ff, sat2_ff;
   // Stage three: minutes, degree term and fraction over sixty.
   logic        v3_ff;
   logic [6:0]  mins3_ff;
   logic [30:0] dege7_3_ff;
   logic [17:0] fdiv3_ff;
   logic        neg3_ff, sat3_ff;
   // Stage four: minute term and partial sum.
   logic        v4_ff;
   logic [24:0] mterm4_ff;
   logic [31:0] part4_ff;
   logic        neg4_ff, sat4_ff;
   // Result register.
   logic        vo_ff;
   logic [31:0] deg_out_ff;
   logic        sat_out_ff;

   logic        rdy2, rdy3, rdy4, rdyo;
   logic [27:0] deg_in;
   logic [39:0] fprod_in;
   logic [14:0] hund_in;
   logic [48:0] fdiv_in;
   logic [32:0] mterm_in;
   logic [31:0] mag_in;

   assign rdyo = !vo_ff || !rsp_stall;
   assign rdy4 = !v4_ff || rdyo;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign conv_ready = rdy2;

   assign deg_in   = 28'(snap.whole) * 28'(DIV100_MUL);
   assign fprod_in = 40'(snap.frac) * 40'(frac_scale(snap.count));
   assign hund_in  = 15'(deg2_ff) * 15'(HUNDRED);
   assign fdiv_in  = 49'(fprod2_ff) * 49'(DIV60_MUL);
   assign mterm_in = 33'(mins3_ff) * 33'(MINS_MUL);
   assign mag_in   = part4_ff + 32'(mterm4_ff);

   always_ff @(posedge clock) begin
      if (rdy2) begin
         whole2_ff <= snap.whole;
         deg2_ff   <= deg_in[DIV100_SHIFT +: 8];
         fprod2_ff <= fprod_in[23:0];
         neg2_ff   <= snap.negate;
         sat2_ff   <= snap.saturated;
      end
      if (rdy3) begin
         mins3_ff   <= 7'(whole2_ff - hund_in);
         dege7_3_ff <= 31'(32'(deg2_ff) * 32'(DEG_SCALE));
         fdiv3_ff   <= fdiv_in[DIV60_SHIFT +: 18];
         neg3_ff    <= neg2_ff;
         sat3_ff    <= sat2_ff;
      end
      if (rdy4) begin
         mterm4_ff <= mterm_in[MINS_SHIFT +: 25];
         part4_ff  <= 32'(dege7_3_ff) + 32'(fdiv3_ff);
         neg4_ff   <= neg3_ff;
         sat4_ff   <= sat3_ff;
      end
      if (rdyo) begin
         deg_out_ff <= neg4_ff ? (32'd0 - mag_in) : mag_in;
         sat_out_ff <= sat4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (rdy2) begin
            v2_ff <= snap.valid;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
         if (rdy4) begin
            v4_ff <= v3_ff;
         end
         if (rdyo) begin
            vo_ff <= v4_ff;
         end
      end
   end

   assign rsp_valid      = vo_ff;
   assign rsp_degrees_e7 = $signed(deg_out_ff);
   assign rsp_over_range = sat_out_ff;

endmodule

// File: src/nmea_latlon_to_fixed_degrees_top.sv
// Converts one NMEA coordinate field of the form DDDMM.mmmm, delivered one ASCII
// character per input item, into a signed fixed-point angle in units of 1e-7
// degree. The item that carries field_end also carries the hemisphere flag and
// causes exactly one result item, which passes through the snapshot register,
// pipeline stages two to four and the result register; every other item causes
// none. One input item is accepted in every clock cycle while req_stall is low,
// set by the digit accumulator, and the conversion pipeline behind it takes a
// new field on every cycle while the result side does not stall. The whole part
// saturates at 18099 and raises over_range; a fraction longer than six
// characters, a missing point or an empty fraction contributes nothing, and a
// sign or whitespace counts as a non-digit. South and west are negated.
module nmea_latlon_to_fixed_degrees_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_char_code,
   input  logic               req_field_end,
   input  logic               req_negate_hemisphere,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_degrees_e7,
   output logic               rsp_over_range
);
   import nlfd_pkg::*;

   // Snapshot of a finished field passing from the accumulator to the pipeline.
   snap_type snap;
   // The pipeline can take a snapshot in this cycle.
   logic     conv_ready;

   // Character accumulator: whole part, fraction and counts, one item a cycle.
   // It holds a finished field in its snapshot register until the pipeline
   // takes it, and stalls the input only while that snapshot cannot move on.
   nlfd_accum u_accum (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_char_code         (req_char_code),
      .req_field_end         (req_field_end),
      .req_negate_hemisphere (req_negate_hemisphere),
      .conv_ready            (conv_ready),
      .snap                  (snap)
   );

   // Conversion pipeline: splits degrees from minutes by reciprocal
   // multiplication, scales both minute terms by 1e7 / 60, sums and applies
   // the hemisphere sign. Each stage holds its item while the next is full and stalled.
   nlfd_convert u_convert (
      .clock          (clock),
      .reset          (reset),
      .snap           (snap),
      .conv_ready     (conv_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_degrees_e7 (rsp_degrees_e7),
      .rsp_over_range (rsp_over_range)
   );

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

   // Run sizing. The timeout is far beyond the slowest legal run, even with
   // heavy idling on both sides.
   localparam int unsigned ITEM_TARGET  = 1650;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned REPORT_LIMIT = 10;

   // Idling percentages for the two busy phases of the run.
   localparam int unsigned IDLE_LIGHT = 15;
   localparam int unsigned IDLE_HEAVY = 45;

   // Character codes and limits of the coordinate format.
   localparam logic [7:0]      ASCII_ZERO  = 8'h30;
   localparam logic [7:0]      ASCII_NINE  = 8'h39;
   localparam logic [7:0]      ASCII_POINT = 8'h2E;
   localparam int unsigned     WHOLE_LIMIT = 18099;
   localparam int unsigned     FRAC_DIGITS = 6;
   localparam int unsigned     COUNT_LIMIT = 7;
   localparam longint unsigned DEG_UNIT    = 10000000;

   // One character item as the sender presents it.
   typedef struct packed {
      logic [7:0] code;
      logic       fin;
      logic       neg;
   } char_item_type;

   // One converted coordinate as the block should return it.
   typedef struct packed {
      logic signed [31:0] deg;
      logic               over;
   } fix_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_char_code = 8'h00;
   logic               req_field_end = 1'b0;
   logic               req_negate_hemisphere = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_degrees_e7;
   logic               rsp_over_range;

   nmea_latlon_to_fixed_degrees_top u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_char_code         (req_char_code),
      .req_field_end         (req_field_end),
      .req_negate_hemisphere (req_negate_hemisphere),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_degrees_e7        (rsp_degrees_e7),
      .rsp_over_range        (rsp_over_range)
   );

   always #6 clock = ~clock;

   // Items waiting to be offered, the field under construction, and the
   // coordinates that accepted fields are owed.
   char_item_type  char_backlog[$];
   logic [7:0]     field_buf[$];
   fix_result_type fix_expected[$];
   char_item_type  next_item;

   // The predictor's own copy of the field parser's state.
   logic [14:0] whole_acc  = '0;
   bit          whole_halt = 1'b0;
   bit          whole_sat  = 1'b0;
   bit          point_got  = 1'b0;
   logic [19:0] frac_acc   = '0;
   bit          frac_halt  = 1'b0;
   logic [2:0]  frac_cnt   = '0;

   bit          req_taken = 1'b0;
   int unsigned items_total  = 0;
   int unsigned fields_total = 0;
   int unsigned chars_sent   = 0;
   int unsigned results_seen = 0;
   int unsigned sat_results  = 0;
   int unsigned neg_results  = 0;
   int unsigned mismatches   = 0;

   // The weight that lifts a fraction of n characters to seven decimal places.
   // An empty fraction and one that has overflowed both contribute nothing.
   function automatic longint unsigned frac_weight(input logic [2:0] n);
      longint unsigned w;
      if (n == 0 || n == COUNT_LIMIT) begin
         return 0;
      end
      w = 1;
      repeat (7 - n) w = w * 10;
      return w;
   endfunction

   // Feeds one accepted character to the predictor. On the final character of
   // a field it forms the expected coordinate and then clears the parser.
   task automatic take_character(input logic [7:0] code, input logic fin, input logic neg);
      bit              digit;
      longint unsigned d;
      longint unsigned nxt;
      longint unsigned deg;
      longint unsigned mins;
      longint unsigned mag;
      fix_result_type  r;
      digit = (code >= ASCII_ZERO) && (code <= ASCII_NINE);
      d = digit ? code - ASCII_ZERO : 0;
      if (!point_got) begin
         // Before the point: the first non-digit freezes the whole part, but a
         // later point is still recognised.
         if (code == ASCII_POINT) begin
            point_got = 1'b1;
         end else if (!digit) begin
            whole_halt = 1'b1;
         end else if (!whole_halt) begin
            nxt = whole_acc * 10 + d;
            if (whole_sat || nxt > WHOLE_LIMIT) begin
               whole_acc = WHOLE_LIMIT;
               whole_sat = 1'b1;
            end else begin
               whole_acc = nxt[14:0];
            end
         end
      end else begin
         // After the point every character is counted, but only leading digits
         // up to the sixth are accumulated.
         if (!digit) begin
            frac_halt = 1'b1;
         end else if (!frac_halt && frac_cnt < FRAC_DIGITS) begin
            frac_acc = frac_acc * 10 + d;
         end
         if (frac_cnt < COUNT_LIMIT) begin
            frac_cnt = frac_cnt + 1;
         end
      end
      if (fin) begin
         deg  = whole_acc / 100;
         mins = whole_acc % 100;
         mag  = deg * DEG_UNIT + (mins * DEG_UNIT) / 60
                + (frac_acc * frac_weight(frac_cnt)) / 60;
         r.deg  = neg ? -mag[31:0] : mag[31:0];
         r.over = whole_sat;
         fix_expected.push_back(r);
         if (whole_sat) sat_results++;
         if (neg) neg_results++;
         whole_acc  = '0;
         whole_halt = 1'b0;
         whole_sat  = 1'b0;
         point_got  = 1'b0;
         frac_acc   = '0;
         frac_halt  = 1'b0;
         frac_cnt   = '0;
      end
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         field_buf.push_back(s[i]);
      end
   endtask

   // Moves the field under construction into the backlog, with the end mark
   // and the hemisphere flag on its last character.
   task automatic close_field(input bit south_west);
      char_item_type it;
      for (int i = 0; i < field_buf.size(); i++) begin
         it.code = field_buf[i];
         it.fin  = (i == field_buf.size() - 1);
         it.neg  = south_west;
         char_backlog.push_back(it);
      end
      field_buf.delete();
      fields_total++;
   endtask

   // The run falls into three equal parts by accepted items: a fast sender
   // with a busy receiver, then the reverse, then no idling at all.
   function automatic int unsigned idle_pct(input bit receiver);
      int unsigned phase;
      phase = (items_total == 0) ? 0 : (chars_sent * 3) / items_total;
      case (phase)
         0:       return receiver ? IDLE_HEAVY : IDLE_LIGHT;
         1:       return receiver ? IDLE_LIGHT : IDLE_HEAVY;
         default: return 0;
      endcase
   endfunction

   // Acceptance: a character item moves at a rising edge where valid is high
   // and stall is low. The predictor sees it at that same edge.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            take_character(req_char_code, req_field_end, req_negate_hemisphere);
            chars_sent++;
         end
      end
   end

   // Sender: at each falling edge, once the offered item has gone (or nothing
   // is offered), it either idles or presents the next item. A stalled item is
   // held unchanged, and the choice to idle never looks at stall.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (char_backlog.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
            next_item = char_backlog.pop_front();
            req_valid             <= 1'b1;
            req_char_code         <= next_item.code;
            req_field_end         <= next_item.fin;
            req_negate_hemisphere <= next_item.neg;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stall is drawn afresh at every falling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < idle_pct(1'b1));
   end

   // Monitor: every accepted coordinate is checked against the oldest one owed.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (fix_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("Unexpected result item: degrees_e7=%0d over_range=%0b",
                        rsp_degrees_e7, rsp_over_range);
            end
         end else begin
            if (rsp_degrees_e7 !== fix_expected[0].deg ||
                rsp_over_range !== fix_expected[0].over) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display({"Mismatch on result %0d: expected degrees_e7=%0d ",
                            "over_range=%0b, got degrees_e7=%0d over_range=%0b"},
                           results_seen, fix_expected[0].deg, fix_expected[0].over,
                           rsp_degrees_e7, rsp_over_range);
               end
            end
            fix_expected.delete(0);
            results_seen++;
         end
      end
   end

   // A stuck handshake ends the run here.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Run stopped at the cycle limit with %0d of %0d items accepted.",
               chars_sent, items_total);
      $display("FAILURE");
      $finish;
   end

   initial begin
      int unsigned kind;
      int unsigned n_whole;
      int unsigned n_frac;
      int unsigned n_noise;
      int unsigned pos;
      int unsigned sel;

      // Directed fields. A lone point on the final item gives an empty
      // fraction and shows that the marked character is parsed first.
      put_text(".");
      close_field(1'b1);
      // A whole part that goes past the limit saturates and flags it.
      put_text("18100");
      close_field(1'b1);
      // A leading sign freezes the whole part, whitespace is just another
      // non-digit, the point is still found, and an all-ones byte after the
      // point stops the fraction while still being counted.
      put_text("-1 2.5");
      field_buf.push_back(8'hFF);
      close_field(1'b0);
      // No point at all, with a zero byte as the final character.
      put_text("1");
      field_buf.push_back(8'h00);
      close_field(1'b1);
      // Seven characters of fraction, which therefore contribute nothing.
      put_text("1.1234567");
      close_field(1'b0);

      // Random fields: mostly well-formed coordinates with random digits, some
      // with a stray character, some pure noise, and now and then the largest.
      while (char_backlog.size() < ITEM_TARGET) begin
         kind = $urandom_range(99);
         if (kind < 3) begin
            put_text("18099.999999");
         end else if (kind < 85) begin
            n_whole = ($urandom_range(19) == 0) ? 6 : $urandom_range(1, 5);
            for (int i = 0; i < n_whole; i++) begin
               // Long whole parts mostly start low so that only some saturate.
               if (i == 0 && n_whole >= 5 && $urandom_range(9) < 7) begin
                  field_buf.push_back(8'(ASCII_ZERO + $urandom_range(1)));
               end else begin
                  field_buf.push_back(8'(ASCII_ZERO + $urandom_range(9)));
               end
            end
            if ($urandom_range(9) != 0) begin
               field_buf.push_back(ASCII_POINT);
               n_frac = ($urandom_range(6) == 0) ? $urandom_range(7, 9) : $urandom_range(6);
               for (int i = 0; i < n_frac; i++) begin
                  field_buf.push_back(8'(ASCII_ZERO + $urandom_range(9)));
               end
            end
            if (kind >= 70) begin
               pos = $urandom_range(field_buf.size() - 1);
               case ($urandom_range(3))
                  0:       field_buf[pos] = "-";
                  1:       field_buf[pos] = " ";
                  2:       field_buf[pos] = "+";
                  default: field_buf[pos] = 8'($urandom_range(255));
               endcase
            end
         end else begin
            n_noise = $urandom_range(1, 8);
            for (int i = 0; i < n_noise; i++) begin
               sel = $urandom_range(9);
               if (sel < 4) begin
                  field_buf.push_back(8'($urandom_range(255)));
               end else if (sel < 6) begin
                  // Neighbours of the digit range and the usual separators.
                  case ($urandom_range(3))
                     0:       field_buf.push_back("/");
                     1:       field_buf.push_back(":");
                     2:       field_buf.push_back("-");
                     default: field_buf.push_back(" ");
                  endcase
               end else if (sel < 8) begin
                  field_buf.push_back(8'(ASCII_ZERO + $urandom_range(9)));
               end else begin
                  field_buf.push_back(ASCII_POINT);
               end
            end
         end
         close_field($urandom_range(1));
      end
      items_total = char_backlog.size();

      // Reset is held from the start and released at a falling edge.
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait until every item has been accepted and every coordinate returned,
      // then give the pipeline time to show anything it should not send.
      while (char_backlog.size() != 0 || req_valid) @(posedge clock);
      while (fix_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fix_expected.size() != 0) begin
         mismatches++;
         $display("%0d expected results never arrived.", fix_expected.size());
      end
      $display("Covered %0d characters in %0d fields under three idling regimes.",
               items_total, fields_total);
      $display("Checked %0d coordinates, %0d saturated and %0d south or west; %0d mismatches.",
               results_seen, sat_results, neg_results, mismatches);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
